### hw/rtl/mma_pkg.sv
// Package for the MIDI message assembler: constants, kinds and status classification.
`default_nettype none

package mma_pkg;

	localparam logic [7:0] STATUS_BIT  = 8'h80;
	localparam logic [7:0] SYSTEM_BASE = 8'hF0;
	localparam logic [3:0] SKIP_RESET  = 4'd10;

	// status byte values named where the classifier needs them
	localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
	localparam logic [7:0] ST_NOTE_ON    = 8'h90;
	localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
	localparam logic [7:0] ST_CTRL_CHG   = 8'hB0;
	localparam logic [7:0] ST_PROG_CHG   = 8'hC0;
	localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
	localparam logic [7:0] ST_PITCH_BEND = 8'hE0;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SONG_POS   = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
	localparam logic [7:0] ST_EOX        = 8'hF7;
	localparam logic [7:0] ST_ACT_SENSE  = 8'hFE;
	localparam logic [7:0] ST_SYS_RESET  = 8'hFF;

	typedef enum logic [2:0] {
		KIND_DROP,
		KIND_SENSE,
		KIND_LEN2,
		KIND_LEN3,
		KIND_NOW
	} kind_t;

	// channel messages classify on the high nibble, system bytes on the whole byte
	function automatic kind_t classify(input logic [7:0] s);
		logic [7:0] key;
		kind_t      k;
		key = (s < SYSTEM_BASE) ? (s & 8'hF0) : s;
		unique case (key)
			ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL_CHG,
			ST_PITCH_BEND, ST_SONG_POS:            k = KIND_LEN3;
			ST_PROG_CHG, ST_CHAN_PRESS, ST_SONG_SEL: k = KIND_LEN2;
			ST_SYSEX, ST_EOX, ST_SYS_RESET:          k = KIND_DROP;
			ST_ACT_SENSE:                            k = KIND_SENSE;
			default:                                 k = KIND_NOW;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mma_if.sv
// Channel interfaces of the MIDI message assembler: byte in, message out, config write.
`default_nettype none

interface mma_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mma_msg_if;
	logic       valid;
	logic       ready;
	logic       msg_valid;
	logic [7:0] status_byte;
	logic [7:0] data_first;
	logic [7:0] data_second;
	logic [1:0] msg_length;
	logic       activity_pulse;
	modport source (output valid, output msg_valid, output status_byte, output data_first,
		output data_second, output msg_length, output activity_pulse, input ready);
	modport sink   (input valid, input msg_valid, input status_byte, input data_first,
		input data_second, input msg_length, input activity_pulse, output ready);
endinterface

interface mma_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] flash_skip;
	modport source (output valid, output flash_skip, input ready);
	modport sink   (input valid, input flash_skip, output ready);
endinterface

`default_nettype wire

### hw/rtl/midi_message_assembler_top.sv
// Top level of the MIDI message assembler with running status and activity flash.
//
//  channel | dir | words                 | notes
//  --------+-----+-----------------------+------------------------------------
//  rx      | in  | rx_byte               | one received MIDI byte per word
//  msg     | out | msg_valid ... pulse   | exactly one word per rx word
//  cfg     | in  | flash_skip            | always ready, write while idle
//
//  Each byte is decoded against the parser state in the cycle it is
//  accepted and the result word lands in the output register at that edge.
//  rx.ready is high whenever the output register is empty or being drained, so a new
//  byte is taken every cycle while msg keeps up; a stall on msg holds one word and stops rx.
//  Reset clears the parser state, the activity counter and the output valid; flash_skip
//  returns to 10.
`default_nettype none

module midi_message_assembler_top (
	input  wire         clk,
	input  wire         arst_n,
	mma_rx_if.sink      rx,
	mma_msg_if.source   msg,
	mma_cfg_if.sink     cfg
);

	// parser state
	logic [7:0] last_status_q;
	logic [1:0] byte_count_q;
	logic [7:0] data0_q;
	logic [7:0] data1_q;
	logic [3:0] sense_count_q;
	logic [3:0] flash_skip_q;

	// output register
	logic       out_valid_q;
	logic       msg_valid_q;
	logic [7:0] status_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic [1:0] length_q;
	logic       pulse_q;

	// next-state and result of the current byte
	logic [7:0]    b;
	logic          take;
	logic [7:0]    last_status_d;
	logic [1:0]    byte_count_d;
	logic [7:0]    data0_d;
	logic [7:0]    data1_d;
	logic [3:0]    sense_count_d;
	logic [1:0]    count;
	mma_pkg::kind_t kind;
	logic          r_valid;
	logic [7:0]    r_status;
	logic [7:0]    r_first;
	logic [7:0]    r_second;
	logic [1:0]    r_length;
	logic          r_pulse;

	assign b        = rx.rx_byte;
	assign rx.ready = !out_valid_q || msg.ready;
	assign take     = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		last_status_d = last_status_q;
		byte_count_d  = byte_count_q;
		data0_d       = data0_q;
		data1_d       = data1_q;
		sense_count_d = sense_count_q;
		r_valid       = 1'b0;
		r_status      = 8'h00;
		r_first       = 8'h00;
		r_second      = 8'h00;
		r_length      = 2'd0;
		r_pulse       = 1'b0;
		count         = 2'd1;
		kind          = mma_pkg::KIND_DROP;

		if (byte_count_q == 2'd0) begin
			if (b >= mma_pkg::STATUS_BIT) begin
				last_status_d = b;
				count         = 2'd1;
			end else begin
				data0_d = b;
				count   = 2'd2;
			end
		end else begin
			// inside a message every byte is data, status bit or not
			if (byte_count_q == 2'd1) data0_d = b;
			else                      data1_d = b;
			count = byte_count_q + 2'd1;
		end

		kind = mma_pkg::classify(last_status_d);

		// idle data byte with no status seen yet: stored, and only a word with msg_valid low goes out
		if (byte_count_q == 2'd0 && b < mma_pkg::STATUS_BIT
				&& last_status_q < mma_pkg::STATUS_BIT) begin
			byte_count_d = byte_count_q;
		end else begin
			priority case (1'b1)
				kind == mma_pkg::KIND_SENSE: begin
					if (sense_count_q >= flash_skip_q) begin
						sense_count_d = 4'd0;
						r_pulse       = 1'b1;
					end else begin
						sense_count_d = sense_count_q + 4'd1;
					end
					byte_count_d = 2'd0;
				end
				kind == mma_pkg::KIND_DROP: byte_count_d = 2'd0;
				kind == mma_pkg::KIND_NOW
				|| (kind == mma_pkg::KIND_LEN2 && count >= 2'd2)
				|| (kind == mma_pkg::KIND_LEN3 && count == 2'd3): begin
					r_valid      = 1'b1;
					r_status     = last_status_d;
					r_first      = (count >= 2'd2) ? data0_d : 8'h00;
					r_second     = (count == 2'd3) ? data1_d : 8'h00;
					r_length     = count;
					byte_count_d = 2'd0;
				end
				default: byte_count_d = count;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_status_q <= 8'h00;
			byte_count_q  <= 2'd0;
			data0_q       <= 8'h00;
			data1_q       <= 8'h00;
			sense_count_q <= 4'd0;
			flash_skip_q  <= mma_pkg::SKIP_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) flash_skip_q <= cfg.flash_skip;
			if (take) begin
				last_status_q <= last_status_d;
				byte_count_q  <= byte_count_d;
				data0_q       <= data0_d;
				data1_q       <= data1_d;
				sense_count_q <= sense_count_d;
				out_valid_q   <= 1'b1;
			end else if (msg.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			msg_valid_q <= r_valid;
			status_q    <= r_status;
			first_q     <= r_first;
			second_q    <= r_second;
			length_q    <= r_length;
			pulse_q     <= r_pulse;
		end
	end

	assign msg.valid          = out_valid_q;
	assign msg.msg_valid      = msg_valid_q;
	assign msg.status_byte    = status_q;
	assign msg.data_first     = first_q;
	assign msg.data_second    = second_q;
	assign msg.msg_length     = length_q;
	assign msg.activity_pulse = pulse_q;

endmodule

`default_nettype wire

### tb/midi_message_assembler_top_tb.sv
// Testbench for the MIDI message assembler: directed and random byte streams checked per word.
`timescale 1ns / 1ps

module midi_message_assembler_top_tb;

	// one result word as the msg channel carries it
	typedef struct packed {
		logic       msg_valid;
		logic [7:0] status_byte;
		logic [7:0] data_first;
		logic [7:0] data_second;
		logic [1:0] msg_length;
		logic       activity_pulse;
	} msg_word_t;

	logic clk;
	logic arst_n;

	mma_rx_if  rx ();
	mma_msg_if msg ();
	mma_cfg_if cfg ();

	midi_message_assembler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.msg    (msg),
		.cfg    (cfg)
	);

	// parser state as the predictor sees it
	logic [7:0] held_status;
	logic [1:0] parse_count;
	logic [7:0] held_data [2];
	logic [3:0] sense_count;
	logic [3:0] skip_model;

	msg_word_t expected_words [$];

	// idle controls for the sender (gaps) and the receiver (stalls, hold-off)
	bit gap_on;
	bit stall_on;
	int hold_len;

	// bookkeeping for the closing summary
	int unsigned bytes_sent;
	int unsigned words_checked;
	int unsigned messages_seen;
	int unsigned pulses_seen;
	int unsigned skip_writes;
	int unsigned mismatches;

	logic [7:0] run_status;

	// clock: 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// what the parser does with a given status byte
	function automatic mma_pkg::kind_t rule_of(input logic [7:0] s);
		mma_pkg::kind_t k;
		if (s < mma_pkg::SYSTEM_BASE) begin
			// channel voice: only program change and channel pressure are short
			if ({s[7:4], 4'h0} == mma_pkg::ST_PROG_CHG
					|| {s[7:4], 4'h0} == mma_pkg::ST_CHAN_PRESS)
				k = mma_pkg::KIND_LEN2;
			else
				k = mma_pkg::KIND_LEN3;
		end else begin
			case (s)
				mma_pkg::ST_SONG_POS:  k = mma_pkg::KIND_LEN3;
				mma_pkg::ST_SONG_SEL:  k = mma_pkg::KIND_LEN2;
				mma_pkg::ST_SYSEX, mma_pkg::ST_EOX,
				mma_pkg::ST_SYS_RESET: k = mma_pkg::KIND_DROP;
				mma_pkg::ST_ACT_SENSE: k = mma_pkg::KIND_SENSE;
				default:               k = mma_pkg::KIND_NOW;
			endcase
		end
		return k;
	endfunction

	// advance the parser by one accepted byte and queue the word it yields
	task automatic predict_byte(input logic [7:0] b);
		msg_word_t      w;
		logic [2:0]     cnt;
		logic [2:0]     need;
		mma_pkg::kind_t k;
		bit             orphan;
		w = '0;
		orphan = 1'b0;
		cnt = 3'd0;
		if (parse_count == 2'd0) begin
			if (b[7]) begin
				held_status = b;
				cnt = 3'd1;
			end else begin
				// data while idle: running status, or an orphan if no status yet
				held_data[0] = b;
				orphan = !held_status[7];
				cnt = 3'd2;
			end
		end else begin
			// inside a message every byte is data, status bit or not
			held_data[!parse_count[0]] = b;
			cnt = {1'b0, parse_count} + 3'd1;
		end
		if (!orphan) begin
			k = rule_of(held_status);
			case (k)
				mma_pkg::KIND_SENSE: begin
					if (sense_count >= skip_model) begin
						sense_count = 4'd0;
						w.activity_pulse = 1'b1;
					end else begin
						sense_count = sense_count + 4'd1;
					end
					parse_count = 2'd0;
				end
				mma_pkg::KIND_DROP: begin
					parse_count = 2'd0;
				end
				default: begin
					need = (k == mma_pkg::KIND_LEN3) ? 3'd3 :
						(k == mma_pkg::KIND_LEN2) ? 3'd2 : 3'd1;
					if (cnt >= need) begin
						w.msg_valid   = 1'b1;
						w.status_byte = held_status;
						w.data_first  = (cnt >= 3'd2) ? held_data[0] : 8'h00;
						w.data_second = (cnt >= 3'd3) ? held_data[1] : 8'h00;
						w.msg_length  = cnt[1:0];
						parse_count   = 2'd0;
					end else begin
						parse_count = cnt[1:0];
					end
				end
			endcase
		end
		expected_words.push_back(w);
	endtask

	// offer one byte on rx after a random gap and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gap_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		predict_byte(b);
		bytes_sent++;
	endtask

	// drop rx valid and let every outstanding word come back
	task automatic settle_idle();
		@(negedge clk);
		rx.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// flash_skip write, only with the parser drained
	task automatic write_skip(input logic [3:0] v);
		settle_idle();
		@(negedge clk);
		cfg.valid      <= 1'b1;
		cfg.flash_skip <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		skip_model = v;
		skip_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// receiver: random stall per word, or one long hold-off when asked
	initial begin : msg_drain
		int stall;
		msg.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, 7) : 0;
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				msg.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			msg.ready <= 1'b1;
			@(posedge clk);
			while (!msg.valid) @(posedge clk);
		end
	end

	// compare every accepted word with the oldest prediction
	always @(posedge clk) begin : check_words
		msg_word_t got;
		msg_word_t want;
		if (arst_n && msg.valid && msg.ready) begin
			got = '{msg.msg_valid, msg.status_byte, msg.data_first, msg.data_second,
				msg.msg_length, msg.activity_pulse};
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word: expected none,", $time);
				$display("%0t:   actual v=%0b st=%h d1=%h d2=%h len=%0d pulse=%0b",
					$time, got.msg_valid, got.status_byte, got.data_first,
					got.data_second, got.msg_length, got.activity_pulse);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (got.msg_valid) messages_seen++;
				if (got.activity_pulse) pulses_seen++;
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch: expected v=%0b st=%h d1=%h d2=%h len=%0d pulse=%0b",
						$time, want.msg_valid, want.status_byte, want.data_first,
						want.data_second, want.msg_length, want.activity_pulse);
					$display("%0t:           actual   v=%0b st=%h d1=%h d2=%h len=%0d pulse=%0b",
						$time, got.msg_valid, got.status_byte, got.data_first,
						got.data_second, got.msg_length, got.activity_pulse);
				end
			end
		end
	end

	// data before any status has been seen: stored, nothing reported
	task automatic test_orphan_data();
		send_byte(8'h00);
		send_byte(8'h7F);
	endtask

	// note off/on, poly pressure, pitch bend with extreme data; the other kinds land as data, then running status
	task automatic test_channel_voice();
		send_byte(mma_pkg::ST_NOTE_OFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(mma_pkg::ST_NOTE_ON | 8'h0F);
		send_byte(8'h7F);
		send_byte(8'h7F);
		send_byte(mma_pkg::ST_POLY_PRESS | 8'h05);
		send_byte(8'h2A);
		send_byte(mma_pkg::ST_CTRL_CHG);
		send_byte(8'h7F);
		send_byte(mma_pkg::ST_PROG_CHG | 8'h03);
		send_byte(8'h55);
		send_byte(mma_pkg::ST_CHAN_PRESS);
		send_byte(mma_pkg::ST_PITCH_BEND | 8'h07);
		send_byte(8'h00);
		send_byte(8'h40);
		send_byte(8'h41);
	endtask

	// system reset is dropped, then a timing clock byte is reported at once
	task automatic test_status_as_data();
		send_byte(8'hFF);
		send_byte(8'hF8);
	endtask

	// song position/select, immediate system bytes, running status after them
	task automatic test_system_bytes();
		send_byte(mma_pkg::ST_SONG_POS);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(mma_pkg::ST_SONG_SEL);
		send_byte(8'h12);
		send_byte(8'hF1);
		send_byte(8'h33);
		send_byte(8'hF8);
	endtask

	// sysex, end of exclusive and reset swallow themselves and running data
	task automatic test_dropped_kinds();
		send_byte(mma_pkg::ST_SYSEX);
		send_byte(8'h12);
		send_byte(mma_pkg::ST_EOX);
		send_byte(mma_pkg::ST_SYS_RESET);
		send_byte(8'h14);
	endtask

	// activity pulse: default skip, lowered below the count, skip of zero
	task automatic test_activity_flash();
		send_byte(mma_pkg::ST_ACT_SENSE);
		send_byte(mma_pkg::ST_ACT_SENSE);
		send_byte(8'h25);
		write_skip(4'd1);
		send_byte(mma_pkg::ST_ACT_SENSE);
		send_byte(mma_pkg::ST_ACT_SENSE);
		write_skip(4'd0);
		send_byte(mma_pkg::ST_ACT_SENSE);
	endtask

	// one random message: mostly well formed, some sensing, some noise
	task automatic send_random_message();
		int             r;
		int             ndata;
		logic [7:0]     st;
		mma_pkg::kind_t k;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			if ($urandom_range(0, 3) == 0 && run_status[7]
					&& run_status < mma_pkg::SYSTEM_BASE) begin
				st = run_status;
			end else begin
				case ($urandom_range(0, 9))
					7: st = mma_pkg::ST_SONG_POS;
					8: st = mma_pkg::ST_SONG_SEL;
					9: st = 8'($urandom_range(241, 255));
					default: st = {4'h8 + 4'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
				endcase
				send_byte(st);
				run_status = st;
			end
			k = rule_of(st);
			ndata = (k == mma_pkg::KIND_LEN3) ? 2 :
				(k == mma_pkg::KIND_LEN2) ? 1 : $urandom_range(0, 1);
			repeat (ndata) send_byte(8'($urandom_range(0, 127)));
		end else if (r < 84) begin
			repeat ($urandom_range(1, 3)) send_byte(mma_pkg::ST_ACT_SENSE);
			if ($urandom_range(0, 2) == 0)
				send_byte(8'($urandom_range(0, 127)));
			run_status = mma_pkg::ST_ACT_SENSE;
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// random phases over skip settings and idle patterns, one with a long hold-off
	task automatic test_random_stream();
		logic [3:0] skips [8];
		int unsigned phase_end;
		skips = '{4'd0, 4'd15, 4'd10, 4'd1, 4'($urandom_range(0, 15)), 4'd7,
			4'($urandom_range(0, 15)), 4'd15};
		for (int p = 0; p < 8; p++) begin
			write_skip(skips[p]);
			gap_on   = (p % 4 == 0) || (p % 4 == 2);
			stall_on = (p % 4 == 0) || (p % 4 == 3);
			// receiver sits out while the sender keeps pushing bytes
			if (p == 1) hold_len = 250;
			phase_end = bytes_sent + 200;
			while (bytes_sent < phase_end) send_random_message();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		rx.valid       = 1'b0;
		rx.rx_byte     = 8'h00;
		cfg.valid      = 1'b0;
		cfg.flash_skip = 4'd0;
		gap_on         = 1'b1;
		stall_on       = 1'b1;
		hold_len       = 0;
		held_status    = 8'h00;
		parse_count    = 2'd0;
		held_data[0]   = 8'h00;
		held_data[1]   = 8'h00;
		sense_count    = 4'd0;
		skip_model     = mma_pkg::SKIP_RESET;
		run_status     = 8'h00;
		bytes_sent     = 0;
		words_checked  = 0;
		messages_seen  = 0;
		pulses_seen    = 0;
		skip_writes    = 0;
		mismatches     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_orphan_data();
		test_channel_voice();
		send_byte(mma_pkg::ST_NOTE_ON);
		test_status_as_data();
		test_system_bytes();
		test_dropped_kinds();
		test_activity_flash();
		test_random_stream();

		settle_idle();
		repeat (10) @(posedge clk);

		$display("Run covered %0d bytes, %0d words checked, %0d messages, %0d activity pulses,",
			bytes_sent, words_checked, messages_seen, pulses_seen);
		$display("%0d flash_skip writes, random idling on both sides and one long output hold-off.",
			skip_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
